### design/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants of the Hamming top-k search unit.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int ENTRIES_DEF    = 1024;
  localparam int MAX_K_DEF      = 16;
  localparam int CODE_WIDTH_DEF = 64;

  localparam int IN_CODE_W  = 64;
  localparam int OUT_IDX_W  = 10;
  localparam int OUT_DIST_W = 7;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBORS = 1'd1;

  localparam logic [6:0] CODE_BITS_RST = 7'd64;
  localparam logic [4:0] NEIGHBORS_RST = 5'd8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

### design/hts_dist.sv
// ----------------------------------------------------------------------------
// hts_dist
// Registered Hamming distance stage: masked XOR and population count.
// ----------------------------------------------------------------------------
module hts_dist #(
  parameter int CODE_WIDTH = 64,
  parameter int IDX_W      = 10,
  parameter int DIST_W     = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [CODE_WIDTH-1:0] data_i,
  input  logic [CODE_WIDTH-1:0] query_i,
  input  logic [CODE_WIDTH-1:0] mask_i,
  output logic                  vld_o,
  output logic [IDX_W-1:0]      idx_o,
  output logic [DIST_W-1:0]     dist_o
);

  localparam int NBYTE = (CODE_WIDTH + 7) / 8;
  localparam int PAD_W = NBYTE * 8;

  logic [PAD_W-1:0]  diff;
  logic [3:0]        byte_cnt [NBYTE];
  logic [DIST_W-1:0] sum;
  logic              vld_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DIST_W-1:0] dist_q;

  assign diff = PAD_W'((data_i ^ query_i) & mask_i);

  always_comb begin
    for (int b = 0; b < NBYTE; b++) begin
      byte_cnt[b] = 4'd0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(diff[b*8+i]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int b = 0; b < NBYTE; b++) begin
      sum = sum + DIST_W'(byte_cnt[b]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_i;
    dist_q <= sum;
  end

  assign vld_o  = vld_q;
  assign idx_o  = idx_q;
  assign dist_o = dist_q;

endmodule

### design/hts_cell.sv
// ----------------------------------------------------------------------------
// hts_cell
// One slot of the sorted insertion chain: keep the better of held and
// incoming candidate, pass the other one to the next slot.
// ----------------------------------------------------------------------------
module hts_cell #(
  parameter int IDX_W  = 10,
  parameter int DIST_W = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              in_vld_i,
  input  logic [IDX_W-1:0]  in_idx_i,
  input  logic [DIST_W-1:0] in_dist_i,
  output logic              hold_vld_o,
  output logic [IDX_W-1:0]  hold_idx_o,
  output logic [DIST_W-1:0] hold_dist_o,
  output logic              pass_vld_o,
  output logic [IDX_W-1:0]  pass_idx_o,
  output logic [DIST_W-1:0] pass_dist_o
);

  logic              hold_vld_q, pass_vld_q;
  logic [IDX_W-1:0]  hold_idx_q, pass_idx_q;
  logic [DIST_W-1:0] hold_dist_q, pass_dist_q;
  logic              better;

  assign better = in_vld_i && (!hold_vld_q || (in_dist_i < hold_dist_q) ||
                  ((in_dist_i == hold_dist_q) && (in_idx_i < hold_idx_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      pass_vld_q <= 1'b0;
    end else if (clr_i) begin
      hold_vld_q <= 1'b0;
      pass_vld_q <= 1'b0;
    end else if (better) begin
      hold_vld_q <= 1'b1;
      pass_vld_q <= hold_vld_q;
    end else begin
      pass_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (better) begin
      hold_idx_q  <= in_idx_i;
      hold_dist_q <= in_dist_i;
      pass_idx_q  <= hold_idx_q;
      pass_dist_q <= hold_dist_q;
    end else begin
      pass_idx_q  <= in_idx_i;
      pass_dist_q <= in_dist_i;
    end
  end

  assign hold_vld_o  = hold_vld_q;
  assign hold_idx_o  = hold_idx_q;
  assign hold_dist_o = hold_dist_q;
  assign pass_vld_o  = pass_vld_q;
  assign pass_idx_o  = pass_idx_q;
  assign pass_dist_o = pass_dist_q;

endmodule

### design/hamming_top_k_search_unit.sv
// ----------------------------------------------------------------------------
// hamming_top_k_search_unit
// Hamming-distance k-nearest search over a store of binary codes.
// ----------------------------------------------------------------------------
// Load request: busy stays low, no result.
// Query request: busy through scan, drain and emit: one store read per cycle,
//   a drain wait for the chain to settle, then min(k, stored) results, one per cycle,
//   the last one in the first cycle with busy low. Empty store: one result next cycle.
// Reset clears the entry count, the chain and the control; store is not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
module hamming_top_k_search_unit #(
  parameter int ENTRIES    = hts_pkg::ENTRIES_DEF,
  parameter int MAX_K      = hts_pkg::MAX_K_DEF,
  parameter int CODE_WIDTH = hts_pkg::CODE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd_i,
  input  logic [hts_pkg::IN_CODE_W-1:0]  code_i,
  input  logic                           cfg_we_i,
  input  logic [hts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hts_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                           res_valid_o,
  output logic [hts_pkg::OUT_IDX_W-1:0]  entry_index_o,
  output logic [hts_pkg::OUT_DIST_W-1:0] distance_o,
  output logic                           empty_res_o,
  output logic                           last_o
);

  import hts_pkg::*;

  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int KW        = $clog2(MAX_K + 1);
  localparam int KIDX_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int DIST_W    = $clog2(CODE_WIDTH + 1);
  localparam int DRAIN_LEN = MAX_K + 1;
  localparam int DRN_W     = $clog2(DRAIN_LEN + 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic [DRN_W-1:0]  drain_q, drain_d;
  logic [KW-1:0]     emit_q, emit_d;
  logic [KW-1:0]     n_q, n_d;
  logic [KW-1:0]     k_eff;
  logic [6:0]        code_bits_q;
  logic [4:0]        neighbors_q;
  logic [6:0]        bits_eff;
  logic [CODE_WIDTH-1:0] qcode_q, qcode_d;
  logic [CODE_WIDTH-1:0] mask_q, mask_d, mask_new;
  logic              mem_we, clr, rd_req;

  logic [CODE_WIDTH-1:0] mem [ENTRIES];
  logic [CODE_WIDTH-1:0] rd_data_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;

  logic              ch_vld  [MAX_K+1];
  logic [IDX_W-1:0]  ch_idx  [MAX_K+1];
  logic [DIST_W-1:0] ch_dist [MAX_K+1];
  logic              cell_vld  [MAX_K];
  logic [IDX_W-1:0]  cell_idx  [MAX_K];
  logic [DIST_W-1:0] cell_dist [MAX_K];

  logic                  res_valid_q, res_valid_d;
  logic [OUT_IDX_W-1:0]  res_idx_q, res_idx_d;
  logic [OUT_DIST_W-1:0] res_dist_q, res_dist_d;
  logic                  res_empty_q, res_empty_d;
  logic                  res_last_q, res_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= CODE_BITS_RST;
      neighbors_q <= NEIGHBORS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CODE_BITS: code_bits_q <= cfg_wdata_i;
        REG_NEIGHBORS: neighbors_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bits_eff = (32'(code_bits_q) > CODE_WIDTH) ? 7'(CODE_WIDTH) : code_bits_q;
    for (int i = 0; i < CODE_WIDTH; i++) begin
      mask_new[i] = (32'(bits_eff) > i);
    end
    if (neighbors_q == 5'd0) begin
      k_eff = KW'(1);
    end else if (32'(neighbors_q) > MAX_K) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(neighbors_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      drain_q     <= '0;
      emit_q      <= '0;
      n_q         <= '0;
      res_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      drain_q     <= drain_d;
      emit_q      <= emit_d;
      n_q         <= n_d;
      res_valid_q <= res_valid_d;
      rd_vld_q    <= rd_req;
    end
  end

  always_ff @(posedge clk_i) begin
    qcode_q     <= qcode_d;
    mask_q      <= mask_d;
    res_idx_q   <= res_idx_d;
    res_dist_q  <= res_dist_d;
    res_empty_q <= res_empty_d;
    res_last_q  <= res_last_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    drain_d     = drain_q;
    emit_d      = emit_q;
    n_d         = n_q;
    qcode_d     = qcode_q;
    mask_d      = mask_q;
    mem_we      = 1'b0;
    clr         = 1'b0;
    rd_req      = 1'b0;
    res_valid_d = 1'b0;
    res_idx_d   = res_idx_q;
    res_dist_d  = res_dist_q;
    res_empty_d = res_empty_q;
    res_last_d  = res_last_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i == CMD_LOAD) begin
            if (32'(count_q) < ENTRIES) begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end else if (count_q == '0) begin
            res_valid_d = 1'b1;
            res_idx_d   = '0;
            res_dist_d  = '0;
            res_empty_d = 1'b1;
            res_last_d  = 1'b1;
          end else begin
            state_d = ST_SCAN;
            scan_d  = '0;
            clr     = 1'b1;
            qcode_d = code_i[CODE_WIDTH-1:0];
            mask_d  = mask_new;
            n_d     = (32'(count_q) < 32'(k_eff)) ? KW'(count_q) : k_eff;
          end
        end
      end
      ST_SCAN: begin
        rd_req = 1'b1;
        if (scan_q == count_q - CNT_W'(1)) begin
          state_d = ST_DRAIN;
          drain_d = DRN_W'(DRAIN_LEN);
        end else begin
          scan_d = scan_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_q == '0) begin
          state_d = ST_EMIT;
          emit_d  = '0;
        end else begin
          drain_d = drain_q - DRN_W'(1);
        end
      end
      ST_EMIT: begin
        res_valid_d = 1'b1;
        res_idx_d   = OUT_IDX_W'(cell_idx[emit_q[KIDX_W-1:0]]);
        res_dist_d  = OUT_DIST_W'(cell_dist[emit_q[KIDX_W-1:0]]);
        res_empty_d = 1'b0;
        res_last_d  = (emit_q == n_q - KW'(1));
        if (emit_q == n_q - KW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          emit_d = emit_q + KW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IDX_W-1:0]] <= code_i[CODE_WIDTH-1:0];
    end
    rd_data_q <= mem[scan_q[IDX_W-1:0]];
    rd_idx_q  <= scan_q[IDX_W-1:0];
  end

  hts_dist #(
    .CODE_WIDTH (CODE_WIDTH),
    .IDX_W      (IDX_W),
    .DIST_W     (DIST_W)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (rd_vld_q),
    .idx_i   (rd_idx_q),
    .data_i  (rd_data_q),
    .query_i (qcode_q),
    .mask_i  (mask_q),
    .vld_o   (ch_vld[0]),
    .idx_o   (ch_idx[0]),
    .dist_o  (ch_dist[0])
  );

  for (genvar g = 0; g < MAX_K; g++) begin : g_cell
    hts_cell #(
      .IDX_W  (IDX_W),
      .DIST_W (DIST_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clr_i       (clr),
      .in_vld_i    (ch_vld[g]),
      .in_idx_i    (ch_idx[g]),
      .in_dist_i   (ch_dist[g]),
      .hold_vld_o  (cell_vld[g]),
      .hold_idx_o  (cell_idx[g]),
      .hold_dist_o (cell_dist[g]),
      .pass_vld_o  (ch_vld[g+1]),
      .pass_idx_o  (ch_idx[g+1]),
      .pass_dist_o (ch_dist[g+1])
    );
  end

  assign busy          = (state_q != ST_IDLE);
  assign res_valid_o   = res_valid_q;
  assign entry_index_o = res_idx_q;
  assign distance_o    = res_dist_q;
  assign empty_res_o   = res_empty_q;
  assign last_o        = res_last_q;

  a_emit_strobes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |=> res_valid_o)
    else $error("emit step without result strobe");

  a_emit_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> cell_vld[emit_q[KIDX_W-1:0]])
    else $error("result read from an empty chain slot");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> (state_q == ST_EMIT))
    else $error("non-final result without a following one");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && empty_res_o) |-> (last_o && (entry_index_o == '0)))
    else $error("empty-store result malformed");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) <= ENTRIES))
    else $error("entry count beyond store depth");

endmodule

### sim/tb_hamming_top_k_search_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hamming_top_k_search_unit
// Loads codes and runs nearest-neighbor queries against the search unit.
// A scoreboard keeps its own copy of the code store and the two registers.
// It ranks the stored codes for every accepted query and checks the strobed
// results in order. Directed cases cover the empty store, zero and saturated
// register values, and distance ties. Random phases mix loads and queries
// under varied settings. A last phase loads more codes and queries at the
// widest settings, then with fewer code bits and neighbors.
// ----------------------------------------------------------------------------
module tb_hamming_top_k_search_unit;
  import hts_pkg::*;

  typedef struct {
    logic [OUT_IDX_W-1:0]  idx;
    logic [OUT_DIST_W-1:0] distance;
    logic                  empty;
    logic                  last;
  } neighbor_t;

  class neighbor_scoreboard;
    logic [IN_CODE_W-1:0] codes [ENTRIES_DEF];
    int unsigned          count;
    logic [6:0]           code_bits;
    logic [4:0]           neighbors;
    neighbor_t            expected_neighbors [$];
    int unsigned          errors;

    function new();
      count     = 0;
      code_bits = CODE_BITS_RST;
      neighbors = NEIGHBORS_RST;
      errors    = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_CODE_BITS) begin
        code_bits = val;
      end else if (idx == REG_NEIGHBORS) begin
        neighbors = val[4:0];
      end
    endfunction

    function int pending();
      return expected_neighbors.size();
    endfunction

    function void note_request(logic cmd, logic [IN_CODE_W-1:0] code);
      int unsigned    bits;
      int unsigned    k;
      int unsigned    fill;
      int unsigned    pos;
      int unsigned    d;
      logic [63:0]    mask;
      int unsigned    top_idx [MAX_K_DEF];
      int unsigned    top_dist [MAX_K_DEF];
      neighbor_t      r;
      if (cmd == CMD_LOAD) begin
        if (count < ENTRIES_DEF) begin
          codes[count] = code;
          count++;
        end
        return;
      end
      if (count == 0) begin
        r.idx      = '0;
        r.distance = '0;
        r.empty    = 1'b1;
        r.last     = 1'b1;
        expected_neighbors.push_back(r);
        return;
      end
      bits = (code_bits > CODE_WIDTH_DEF) ? CODE_WIDTH_DEF : code_bits;
      mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
      k = (neighbors == 0) ? 1 : ((neighbors > MAX_K_DEF) ? MAX_K_DEF : neighbors);
      fill = 0;
      for (int unsigned j = 0; j < count; j++) begin
        d = $countones((code ^ codes[j]) & mask);
        if (fill < k) begin
          pos = fill;
          fill++;
        end else if (d < top_dist[k-1]) begin
          pos = k - 1;
        end else begin
          continue;
        end
        // shift worse entries down; equal distance keeps the lower index first
        while (pos > 0 && top_dist[pos-1] > d) begin
          top_idx[pos]  = top_idx[pos-1];
          top_dist[pos] = top_dist[pos-1];
          pos--;
        end
        top_idx[pos]  = j;
        top_dist[pos] = d;
      end
      for (int unsigned j = 0; j < fill; j++) begin
        r.idx      = OUT_IDX_W'(top_idx[j]);
        r.distance = OUT_DIST_W'(top_dist[j]);
        r.empty    = 1'b0;
        r.last     = (j + 1 == fill);
        expected_neighbors.push_back(r);
      end
    endfunction

    function void check_result(logic [OUT_IDX_W-1:0] idx, logic [OUT_DIST_W-1:0] dist_val,
                               logic empty, logic last);
      neighbor_t e;
      if (expected_neighbors.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: index %0d distance %0d empty %0b last %0b",
                 $time, idx, dist_val, empty, last);
        return;
      end
      e = expected_neighbors.pop_front();
      if ({e.idx, e.distance, e.empty, e.last} !== {idx, dist_val, empty, last}) begin
        errors++;
        $display("%0t: mismatch: expected index %0d distance %0d empty %0b last %0b,",
                 $time, e.idx, e.distance, e.empty, e.last);
        $display("%0t:           actual   index %0d distance %0d empty %0b last %0b",
                 $time, idx, dist_val, empty, last);
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic                  cmd_i       = CMD_LOAD;
  logic [IN_CODE_W-1:0]  code_i      = '0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = REG_CODE_BITS;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  res_valid_o;
  logic [OUT_IDX_W-1:0]  entry_index_o;
  logic [OUT_DIST_W-1:0] distance_o;
  logic                  empty_res_o;
  logic                  last_o;

  neighbor_scoreboard sb = new();

  hamming_top_k_search_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .code_i        (code_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .res_valid_o   (res_valid_o),
    .entry_index_o (entry_index_o),
    .distance_o    (distance_o),
    .empty_res_o   (empty_res_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) begin
        sb.check_result(entry_index_o, distance_o, empty_res_o, last_o);
      end
      if (cfg_we_i) begin
        sb.apply_reg(cfg_idx_i, cfg_wdata_i);
      end
      if (start && !busy) begin
        sb.note_request(cmd_i, code_i);
      end
    end
  end

  function automatic int pick_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IN_CODE_W-1:0] pick_code();
    int unsigned          r;
    logic [IN_CODE_W-1:0] v;
    r = $urandom_range(0, 99);
    v = {$urandom, $urandom};
    if (r < 35 && sb.count > 0) begin
      v = sb.codes[$urandom_range(0, sb.count - 1)];
      repeat ($urandom_range(0, 5)) v[$urandom_range(0, 63)] ^= 1'b1;
    end else if (r < 45) begin
      v = ($urandom_range(0, 1) == 0) ? '0 : '1;
    end else if (r < 52) begin
      v = 64'd1 << $urandom_range(0, 63);
    end
    return v;
  endfunction

  task automatic send(input logic cmd, input logic [IN_CODE_W-1:0] code, input int gap);
    start  <= 1'b1;
    cmd_i  <= cmd;
    code_i <= code;
    do @(posedge clk_i); while (busy);
    if (gap > 0) begin
      start  <= 1'b0;
      cmd_i  <= 1'($urandom_range(0, 1));
      code_i <= {$urandom, $urandom};
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] cb;
    logic [CFG_DATA_W-1:0] nb;
    case ($urandom_range(0, 5))
      0: cb = 7'd0;
      1: cb = 7'd1;
      2: cb = 7'd64;
      3: cb = 7'($urandom_range(65, 127));
      default: cb = 7'($urandom_range(1, 64));
    endcase
    nb = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 2) == 0) nb = 7'($urandom_range(1, 16));
    set_reg(REG_CODE_BITS, cb);
    set_reg(REG_NEIGHBORS, nb);
  endtask

  task automatic run_phase(input int n, input int load_pct, input bit burst);
    for (int i = 0; i < n; i++) begin
      send(($urandom_range(0, 99) < load_pct) ? CMD_LOAD : CMD_QUERY, pick_code(),
           pick_gap(burst));
    end
  endtask

  initial begin
    int load_pct [7] = '{80, 60, 50, 40, 30, 70, 50};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_QUERY, '0, 1);
    send(CMD_QUERY, '1, 0);
    send(CMD_LOAD, '0, 0);
    send(CMD_LOAD, '1, 2);
    send(CMD_LOAD, 64'h5555_5555_5555_5555, 0);
    send(CMD_LOAD, 64'hAAAA_AAAA_AAAA_AAAA, 0);
    send(CMD_LOAD, 64'd1, 1);
    send(CMD_LOAD, 64'h8000_0000_0000_0000, 0);
    send(CMD_LOAD, '0, 0);
    send(CMD_LOAD, {$urandom, $urandom}, 0);
    send(CMD_LOAD, {$urandom, $urandom}, 0);
    send(CMD_QUERY, '0, 0);
    send(CMD_QUERY, '1, 3);
    send(CMD_QUERY, 64'h5555_5555_5555_5555, 0);

    wait_idle();
    set_reg(REG_CODE_BITS, 7'd0);
    set_reg(REG_NEIGHBORS, 7'd0);
    send(CMD_QUERY, {$urandom, $urandom}, 0);
    wait_idle();
    set_reg(REG_CODE_BITS, 7'd127);
    set_reg(REG_NEIGHBORS, 7'd31);
    send(CMD_QUERY, '1, 0);
    wait_idle();
    set_reg(REG_CODE_BITS, 7'd1);
    set_reg(REG_NEIGHBORS, 7'h62);
    send(CMD_QUERY, 64'd1, 0);
    wait_idle();
    set_reg(REG_CODE_BITS, 7'd64);
    set_reg(REG_NEIGHBORS, 7'd16);
    send(CMD_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 0);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      random_config();
      run_phase(58, load_pct[p], (p == 2 || p == 5));
    end

    wait_idle();
    set_reg(REG_CODE_BITS, 7'd64);
    set_reg(REG_NEIGHBORS, 7'd16);
    repeat (6) send(CMD_LOAD, pick_code(), pick_gap(1'b0));
    send(CMD_QUERY, pick_code(), 0);
    send(CMD_QUERY, '1, 0);
    wait_idle();
    set_reg(REG_CODE_BITS, 7'd3);
    send(CMD_QUERY, pick_code(), 2);
    wait_idle();
    set_reg(REG_CODE_BITS, 7'd40);
    set_reg(REG_NEIGHBORS, 7'd1);
    send(CMD_QUERY, pick_code(), 0);

    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
